// ===== rtl/nns_pkg.sv =====
// Shared constants, types and helpers for the nearest-neighbour image scaler.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package nns_pkg;

	localparam int PIX_W          = 32;
	localparam int DIM_W          = 9;
	localparam int MAX_DIM        = 256;
	localparam int MAX_SRC_PIXELS = 65536;
	localparam int ADDR_W         = $clog2(MAX_SRC_PIXELS);
	localparam int PTR_W          = ADDR_W + 1;
	localparam int FRAC_BITS      = 16;
	localparam int ACC_W          = FRAC_BITS + DIM_W;
	localparam int CNT_W          = $clog2(ACC_W);
	localparam int PROD_W         = 2 * DIM_W;
	localparam int CFG_IDX_W      = 2;

	// input commands
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EMIT = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

	typedef struct packed {
		logic load_wr;
		logic div_start;
		logic addr_calc;
		logic mem_rd;
		logic out_load;
	} nns_cmd_t;

	typedef struct packed {
		logic frame_start;
		logic div_busy;
	} nns_sts_t;

	// zero reads as one, anything above MAX_DIM as MAX_DIM
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		else
			r = v;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/nns_cfg_if.sv =====
// Register write channel of the scaler.
// Depends on nns_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface nns_cfg_if
	import nns_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/nns_in_if.sv =====
// Input item channel: load or emit command with a source pixel.
// Depends on nns_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface nns_in_if
	import nns_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [PIX_W-1:0] src_pixel;

	modport source (output valid, cmd, src_pixel, input ready);
	modport sink   (input valid, cmd, src_pixel, output ready);
endinterface

`default_nettype wire

// ===== rtl/nns_out_if.sv =====
// Result channel: destination pixel with row and frame end flags.
// Depends on nns_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface nns_out_if
	import nns_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] out_pixel;
	logic             row_end;
	logic             frame_end;

	modport source (output valid, out_pixel, row_end, frame_end, input ready);
	modport sink   (input valid, out_pixel, row_end, frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/nns_div.sv =====
// Restoring divider lane, one quotient bit per cycle, for the 9.16 step.
// Depends on nns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nns_div
	import nns_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [ACC_W-1:0] num,
	input  wire logic [DIM_W-1:0] den,
	output logic                  busy,
	output logic [ACC_W-1:0]      quot
);

	logic [ACC_W-1:0] num_q;
	logic [DIM_W-1:0] den_q;
	logic [DIM_W-1:0] rem_q;
	logic [ACC_W-1:0] quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	logic [DIM_W:0]   rem_sh;
	logic             fits;
	logic [DIM_W:0]   rem_sub;

	assign rem_sh  = {rem_q, num_q[ACC_W-1]};
	assign fits    = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			quot_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(ACC_W - 1);
		end else if (busy_q) begin
			quot_q <= {quot_q[ACC_W-2:0], fits};
			if (cnt_q == '0)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// remainder stays below the divisor, so it fits DIM_W bits
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[ACC_W-2:0], 1'b0};
			rem_q <= fits ? rem_sub[DIM_W-1:0] : rem_sh[DIM_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

// ===== rtl/nns_dp.sv =====
// Scaler datapath: registers, pixel store, step dividers, address and flag stages.
// Depends on nns_pkg and nns_div.
`timescale 1ns / 1ps
`default_nettype none

module nns_dp
	import nns_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire nns_cmd_t             cmd,
	output nns_sts_t                  sts,
	input  wire logic                 cfg_wr,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [DIM_W-1:0]     cfg_data,
	input  wire logic [PIX_W-1:0]     src_pixel,
	output logic [PIX_W-1:0]          out_pixel,
	output logic                      row_end,
	output logic                      frame_end
);

	logic [DIM_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [PTR_W-1:0] ptr_q;
	logic [ACC_W-1:0] x_acc_q, y_acc_q;
	logic [DIM_W-1:0] col_q, row_q;
	logic [ACC_W-1:0] x_step, y_step;
	logic             x_busy, y_busy;

	logic [PIX_W-1:0] mem [MAX_SRC_PIXELS];

	logic [PROD_W-1:0] addr_s1;
	logic              row_end_s1, frame_end_s1;
	logic [PIX_W-1:0]  rd_s2;
	logic              in_range_s2, row_end_s2, frame_end_s2;
	logic [PIX_W-1:0]  out_pixel_q;
	logic              row_end_q, frame_end_q;

	logic [DIM_W-1:0]  col_inc, row_inc;
	logic              row_wrap, frame_wrap;
	logic [PROD_W-1:0] addr_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= DIM_W'(1);
			src_h_q <= DIM_W'(1);
			dst_w_q <= DIM_W'(1);
			dst_h_q <= DIM_W'(1);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_SRC_WIDTH:  src_w_q <= cfg_data;
				REG_SRC_HEIGHT: src_h_q <= cfg_data;
				REG_DST_WIDTH:  dst_w_q <= cfg_data;
				REG_DST_HEIGHT: dst_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	nns_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    ({eff_dim(src_w_q), FRAC_BITS'(0)}),
		.den    (eff_dim(dst_w_q)),
		.busy   (x_busy),
		.quot   (x_step)
	);

	nns_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    ({eff_dim(src_h_q), FRAC_BITS'(0)}),
		.den    (eff_dim(dst_h_q)),
		.busy   (y_busy),
		.quot   (y_step)
	);

	assign sts = '{frame_start: (col_q == '0) && (row_q == '0),
		div_busy: x_busy || y_busy};

	// load side: pointer stops at capacity, further loads dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ptr_q <= '0;
		else if (cmd.load_wr && !ptr_q[ADDR_W])
			ptr_q <= ptr_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr && !ptr_q[ADDR_W])
			mem[ptr_q[ADDR_W-1:0]] <= src_pixel;
		if (cmd.mem_rd)
			rd_s2 <= mem[addr_s1[ADDR_W-1:0]];
	end

	assign col_inc    = col_q + 1'b1;
	assign row_inc    = row_q + 1'b1;
	assign row_wrap   = (col_inc == '0) || (col_inc >= eff_dim(dst_w_q));
	assign frame_wrap = (row_inc == '0) || (row_inc >= eff_dim(dst_h_q));
	assign addr_nx    = PROD_W'(y_acc_q[ACC_W-1:FRAC_BITS]) * PROD_W'(eff_dim(src_w_q))
		+ PROD_W'(x_acc_q[ACC_W-1:FRAC_BITS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_acc_q <= '0;
			y_acc_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (cmd.addr_calc) begin
			if (!row_wrap) begin
				col_q   <= col_inc;
				x_acc_q <= x_acc_q + x_step;
			end else begin
				col_q   <= '0;
				x_acc_q <= '0;
				if (!frame_wrap) begin
					row_q   <= row_inc;
					y_acc_q <= y_acc_q + y_step;
				end else begin
					row_q   <= '0;
					y_acc_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.addr_calc) begin
			addr_s1      <= addr_nx;
			row_end_s1   <= row_wrap;
			frame_end_s1 <= row_wrap && frame_wrap;
		end
		if (cmd.mem_rd) begin
			in_range_s2  <= (addr_s1 >> ADDR_W) == '0;
			row_end_s2   <= row_end_s1;
			frame_end_s2 <= frame_end_s1;
		end
		if (cmd.out_load)
			out_pixel_q <= in_range_s2 ? rd_s2 : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_end_q   <= 1'b0;
			frame_end_q <= 1'b0;
		end else if (cmd.out_load) begin
			row_end_q   <= row_end_s2;
			frame_end_q <= frame_end_s2;
		end
	end

	assign out_pixel = out_pixel_q;
	assign row_end   = row_end_q;
	assign frame_end = frame_end_q;

	a_frame_implies_row: assert property (@(posedge clk) disable iff (!arst_n)
		frame_end_q |-> row_end_q)
		else $error("frame end without row end");

	a_ptr_capped: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q[ADDR_W] |-> (ptr_q[ADDR_W-1:0] == '0))
		else $error("load pointer beyond store capacity");

	a_ptr_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_wr && !ptr_q[ADDR_W]) |=> (ptr_q == $past(ptr_q) + 1'b1))
		else $error("load pointer did not advance on a load");

endmodule

`default_nettype wire

// ===== rtl/nns_ctrl.sv =====
// Scaler controller: sequences load, step division, address, read and output.
// Depends on nns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nns_ctrl
	import nns_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_cmd,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output nns_cmd_t      cmd,
	input  wire nns_sts_t sts
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_ADDR = 3'd2;
	localparam logic [2:0] ST_READ = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q, state_nx;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_cmd == CMD_EMIT) begin
						if (sts.frame_start) begin
							cmd.div_start = 1'b1;
							state_nx      = ST_DIV;
						end else begin
							state_nx = ST_ADDR;
						end
					end else begin
						cmd.load_wr = 1'b1;
					end
				end
			end
			ST_DIV: begin
				if (!sts.div_busy)
					state_nx = ST_ADDR;
			end
			ST_ADDR: begin
				cmd.addr_calc = 1'b1;
				state_nx      = ST_READ;
			end
			ST_READ: begin
				cmd.mem_rd = 1'b1;
				state_nx   = ST_OUT;
			end
			ST_OUT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before delivery");

	a_div_at_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> sts.frame_start)
		else $error("step division outside frame start");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.out_load))
		else $error("result valid without a loaded result");

endmodule

`default_nettype wire

// ===== rtl/nearest_neighbor_image_scaler.sv =====
// Top level of the nearest-neighbour image scaler.
// Depends on nns_pkg, the nns_*_if interfaces, nns_ctrl and nns_dp.
//
//   channel  dir  beat contents
//   cfg      in   index (2 b), data (9 b): register write, always ready
//   din      in   cmd (1 b), src_pixel (32 b): load or emit request
//   dout     out  out_pixel (32 b), row_end, frame_end: one beat per emit
//
// A load beat is written while idle; an emit goes through the address, store read
// and result register steps. The first emit of each frame also waits for the two
// bit-serial step dividers. The result register lets the next request in
// while a finished beat waits; a stalled dout holds the emit in its last step.
// Reset clears config registers, counters and the load pointer, not the pixel store.
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbor_image_scaler
	import nns_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	nns_cfg_if.sink     cfg,
	nns_in_if.sink      din,
	nns_out_if.source   dout
);

	nns_cmd_t cmd;
	nns_sts_t sts;
	logic     in_ready;
	logic     out_valid;

	assign cfg.ready  = 1'b1;
	assign din.ready  = in_ready;
	assign dout.valid = out_valid;

	nns_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_cmd    (din.cmd),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (dout.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	nns_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_wr    (cfg.valid),
		.cfg_idx   (cfg.index),
		.cfg_data  (cfg.data),
		.src_pixel (din.src_pixel),
		.out_pixel (dout.out_pixel),
		.row_end   (dout.row_end),
		.frame_end (dout.frame_end)
	);

endmodule

`default_nettype wire
